@@ sv/pter_pkg.sv @@
// ----------------------------------------------------------------------------
// pter_pkg: shared types and constants of the point transform rotator
// Holds command codes, sequencer states, the micro-program of the shared
// multiplier and the arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pter_pkg;

   // Fixed widths of the trigonometric path and of the multiplier.
   localparam int TRIG_WIDTH  = 34;
   localparam int ZETA_WIDTH  = 33;
   localparam int MUL_B_WIDTH = 34;
   localparam int CHUNK_WIDTH = 17;
   localparam int FRAC_BITS   = 30;
   localparam int ATAN_DEPTH  = 24;
   localparam int PHASE_WIDTH = 32;
   localparam int UPC_WIDTH   = 6;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

   typedef enum logic [2:0] {
      CMD_LOAD      = 3'd0,
      CMD_TRANSLATE = 3'd1,
      CMD_ROT_X     = 3'd2,
      CMD_ROT_Y     = 3'd3,
      CMD_ROT_Z     = 3'd4,
      CMD_EULER     = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG,
      ST_TRIG_WAIT,
      ST_MUL,
      ST_MUL_WAIT,
      ST_FINISH
   } state_type;

   // Operand and destination registers of the micro-program.
   typedef enum logic [4:0] {
      SEL_PX, SEL_PY, SEL_PZ, SEL_DX, SEL_DY, SEL_DZ,
      SEL_SA, SEL_CA, SEL_SB, SEL_CB, SEL_SG, SEL_CG,
      SEL_SACB, SEL_CACB,
      SEL_R00, SEL_R01, SEL_R02, SEL_R10, SEL_R11, SEL_R12, SEL_R20, SEL_R21,
      SEL_NX, SEL_NY, SEL_NZ
   } sel_type;

   // How a rounded product lands in its destination.
   typedef enum logic [1:0] {
      MOP_SET,
      MOP_ADD,
      MOP_SUB,
      MOP_NEG
   } mop_type;

   typedef struct packed {
      mop_type mop;
      sel_type src_a;
      sel_type src_b;
      sel_type dst;
      logic    last;
   } uop_type;

   localparam logic [UPC_WIDTH-1:0] UPC_ROT_X = 6'd0;
   localparam logic [UPC_WIDTH-1:0] UPC_ROT_Y = 6'd4;
   localparam logic [UPC_WIDTH-1:0] UPC_ROT_Z = 6'd8;
   localparam logic [UPC_WIDTH-1:0] UPC_EULER = 6'd12;

   // Micro-program: one rounded multiply per step.
   function automatic uop_type uop_rom(input logic [UPC_WIDTH-1:0] upc);
      uop_type u;
      case (upc)
         // Rotation about X.
         6'd0:  u = '{MOP_SET, SEL_PY,   SEL_CA, SEL_NY,   1'b0};
         6'd1:  u = '{MOP_SUB, SEL_PZ,   SEL_SA, SEL_NY,   1'b0};
         6'd2:  u = '{MOP_SET, SEL_PY,   SEL_SA, SEL_NZ,   1'b0};
         6'd3:  u = '{MOP_ADD, SEL_PZ,   SEL_CA, SEL_NZ,   1'b1};
         // Rotation about Y.
         6'd4:  u = '{MOP_SET, SEL_PX,   SEL_CA, SEL_NX,   1'b0};
         6'd5:  u = '{MOP_ADD, SEL_PZ,   SEL_SA, SEL_NX,   1'b0};
         6'd6:  u = '{MOP_SET, SEL_PZ,   SEL_CA, SEL_NZ,   1'b0};
         6'd7:  u = '{MOP_SUB, SEL_PX,   SEL_SA, SEL_NZ,   1'b1};
         // Rotation about Z.
         6'd8:  u = '{MOP_SET, SEL_PX,   SEL_CA, SEL_NX,   1'b0};
         6'd9:  u = '{MOP_ADD, SEL_PY,   SEL_SA, SEL_NX,   1'b0};
         6'd10: u = '{MOP_NEG, SEL_PX,   SEL_SA, SEL_NY,   1'b0};
         6'd11: u = '{MOP_ADD, SEL_PY,   SEL_CA, SEL_NY,   1'b1};
         // Euler z-x-z: matrix coefficients first.
         6'd12: u = '{MOP_SET, SEL_SA,   SEL_CB, SEL_SACB, 1'b0};
         6'd13: u = '{MOP_SET, SEL_CA,   SEL_CB, SEL_CACB, 1'b0};
         6'd14: u = '{MOP_SET, SEL_CA,   SEL_CG, SEL_R00,  1'b0};
         6'd15: u = '{MOP_SUB, SEL_SACB, SEL_SG, SEL_R00,  1'b0};
         6'd16: u = '{MOP_SET, SEL_SA,   SEL_CG, SEL_R01,  1'b0};
         6'd17: u = '{MOP_ADD, SEL_CACB, SEL_SG, SEL_R01,  1'b0};
         6'd18: u = '{MOP_SET, SEL_SB,   SEL_SG, SEL_R02,  1'b0};
         6'd19: u = '{MOP_NEG, SEL_CA,   SEL_SG, SEL_R10,  1'b0};
         6'd20: u = '{MOP_SUB, SEL_SACB, SEL_CG, SEL_R10,  1'b0};
         6'd21: u = '{MOP_NEG, SEL_SA,   SEL_SG, SEL_R11,  1'b0};
         6'd22: u = '{MOP_ADD, SEL_CACB, SEL_CG, SEL_R11,  1'b0};
         6'd23: u = '{MOP_SET, SEL_SB,   SEL_CG, SEL_R12,  1'b0};
         6'd24: u = '{MOP_SET, SEL_SA,   SEL_SB, SEL_R20,  1'b0};
         6'd25: u = '{MOP_NEG, SEL_CA,   SEL_SB, SEL_R21,  1'b0};
         // Euler: matrix times offset from the pivot.
         6'd26: u = '{MOP_SET, SEL_DX,   SEL_R00, SEL_NX,  1'b0};
         6'd27: u = '{MOP_ADD, SEL_DY,   SEL_R01, SEL_NX,  1'b0};
         6'd28: u = '{MOP_ADD, SEL_DZ,   SEL_R02, SEL_NX,  1'b0};
         6'd29: u = '{MOP_SET, SEL_DX,   SEL_R10, SEL_NY,  1'b0};
         6'd30: u = '{MOP_ADD, SEL_DY,   SEL_R11, SEL_NY,  1'b0};
         6'd31: u = '{MOP_ADD, SEL_DZ,   SEL_R12, SEL_NY,  1'b0};
         6'd32: u = '{MOP_SET, SEL_DX,   SEL_R20, SEL_NZ,  1'b0};
         6'd33: u = '{MOP_ADD, SEL_DY,   SEL_R21, SEL_NZ,  1'b0};
         6'd34: u = '{MOP_ADD, SEL_DZ,   SEL_CB,  SEL_NZ,  1'b1};
         default: u = '{MOP_SET, SEL_PX, SEL_CA, SEL_NX,  1'b1};
      endcase
      return u;
   endfunction

   // Arctangent of 2^-i as a 32-bit binary angle.
   function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sh20000000;
         5'd1:  v = 32'sh12E4051E;
         5'd2:  v = 32'sh09FB385B;
         5'd3:  v = 32'sh051111D4;
         5'd4:  v = 32'sh028B0D43;
         5'd5:  v = 32'sh0145D7E1;
         5'd6:  v = 32'sh00A2F61E;
         5'd7:  v = 32'sh00517C55;
         5'd8:  v = 32'sh0028BE53;
         5'd9:  v = 32'sh00145F2F;
         5'd10: v = 32'sh000A2F98;
         5'd11: v = 32'sh000517CC;
         5'd12: v = 32'sh00028BE6;
         5'd13: v = 32'sh000145F3;
         5'd14: v = 32'sh0000A2FA;
         5'd15: v = 32'sh0000517D;
         5'd16: v = 32'sh000028BE;
         5'd17: v = 32'sh0000145F;
         5'd18: v = 32'sh00000A30;
         5'd19: v = 32'sh00000518;
         5'd20: v = 32'sh0000028C;
         5'd21: v = 32'sh00000146;
         5'd22: v = 32'sh000000A3;
         5'd23: v = 32'sh00000051;
         default: v = 32'sh00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ sv/pter_cordic.sv @@
// ----------------------------------------------------------------------------
// pter_cordic: iterative sine and cosine unit
// Rotation-mode CORDIC, one micro-rotation per cycle, Q4.30 results.
// ----------------------------------------------------------------------------
`default_nettype none

module pter_cordic #(
   parameter int ANGLE_WIDTH = 16,
   parameter int ITERATIONS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [ANGLE_WIDTH-1:0]                  angle,
   output logic                                    done,
   output logic signed [pter_pkg::TRIG_WIDTH-1:0]  sin_out,
   output logic signed [pter_pkg::TRIG_WIDTH-1:0]  cos_out
);
   import pter_pkg::*;

   localparam int IW = $clog2(ITERATIONS + 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic                         flip_ff;
   logic [IW-1:0]                iter_ff;
   logic signed [TRIG_WIDTH-1:0] x_ff;
   logic signed [TRIG_WIDTH-1:0] y_ff;
   logic signed [ZETA_WIDTH-1:0] z_ff;

   logic [PHASE_WIDTH-1:0]       phase;
   logic                         flip;
   logic [PHASE_WIDTH-1:0]       phase_folded;
   logic signed [TRIG_WIDTH-1:0] dx;
   logic signed [TRIG_WIDTH-1:0] dy;
   logic signed [ZETA_WIDTH-1:0] step_angle;

   // Fold the second and third quadrants onto the first and fourth.
   always_comb begin
      phase        = {angle, {(PHASE_WIDTH-ANGLE_WIDTH){1'b0}}};
      flip         = phase[PHASE_WIDTH-1] ^ phase[PHASE_WIDTH-2];
      phase_folded = {phase[PHASE_WIDTH-1] ^ flip, phase[PHASE_WIDTH-2:0]};
      dx           = y_ff >>> iter_ff;
      dy           = x_ff >>> iter_ff;
      step_angle   = ZETA_WIDTH'(atan_entry(5'(iter_ff)));
   end

   // Control: busy while rotating, done for one cycle at the end.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && iter_ff == IW'(ITERATIONS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Micro-rotations, direction chosen by the sign of the residual angle.
   always_ff @(posedge clock) begin
      if (start) begin
         iter_ff <= '0;
         flip_ff <= flip;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= ZETA_WIDTH'(signed'(phase_folded));
      end else if (busy_ff) begin
         iter_ff <= iter_ff + IW'(1);
         if (!z_ff[ZETA_WIDTH-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - step_angle;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + step_angle;
         end
      end
   end

   assign done    = done_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;

endmodule

`default_nettype wire

@@ sv/pter_mul.sv @@
// ----------------------------------------------------------------------------
// pter_mul: shared multiplier with Q30 rounding
// Multiplies a wide signed operand by a 34-bit coefficient, 17 bits of the
// wide operand per cycle, then rounds half up and drops 30 fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pter_mul #(
   parameter int A_WIDTH   = 34,
   parameter int RES_WIDTH = 38
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [A_WIDTH-1:0]               op_a,
   input  logic signed [pter_pkg::MUL_B_WIDTH-1:0] op_b,
   output logic                                    done,
   output logic signed [RES_WIDTH-1:0]             product
);
   import pter_pkg::*;

   localparam int NCH   = (A_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
   localparam int EXT   = NCH * CHUNK_WIDTH;
   localparam int ACC_W = EXT + MUL_B_WIDTH + 2;
   localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PP_W  = CHUNK_WIDTH + 1 + MUL_B_WIDTH;

   logic                          busy_ff;
   logic                          fin_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic signed [EXT-1:0]         a_ff;
   logic signed [MUL_B_WIDTH-1:0] b_ff;
   logic signed [ACC_W-1:0]       acc_ff;

   logic [CHUNK_WIDTH-1:0]        chunk;
   logic signed [CHUNK_WIDTH:0]   chunk_s;
   logic signed [PP_W-1:0]        pp;
   logic signed [ACC_W-1:0]       rounded;

   // Top chunk is signed, the lower chunks are unsigned.
   always_comb begin
      chunk   = a_ff[cnt_ff*CHUNK_WIDTH +: CHUNK_WIDTH];
      chunk_s = (cnt_ff == CNT_W'(NCH - 1)) ? {chunk[CHUNK_WIDTH-1], chunk}
                                            : {1'b0, chunk};
      pp      = chunk_s * b_ff;
      rounded = acc_ff + (ACC_W'(1) <<< (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end
   end

   // Accumulate partial products from the most significant chunk down.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= EXT'(op_a);
         b_ff   <= op_b;
         cnt_ff <= CNT_W'(NCH - 1);
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= (acc_ff <<< CHUNK_WIDTH) + ACC_W'(pp);
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done    = fin_ff;
   assign product = signed'(rounded[FRAC_BITS +: RES_WIDTH]);

endmodule

`default_nettype wire

@@ sv/point_transform_euler_rotator.sv @@
// ----------------------------------------------------------------------------
// point_transform_euler_rotator: fixed-point 3D point transform
// Holds one point and loads, translates or rotates it per request; the
// updated point is returned, saturated, after every request.
// ----------------------------------------------------------------------------
//  Channel  | Ports                            | Handshake
//  request  | req_cmd, req_val_*, req_angle_*  | req_valid / req_ready
//  response | rsp_out_x, rsp_out_y, rsp_out_z | rsp_valid / rsp_ready
//
//  Every request is taken in the idle state and ends in the finishing state,
//  which waits while an earlier response is still pending; load, translate
//  and unknown commands go straight from one to the other. A single-axis
//  rotation adds a CORDIC run and 4 multiplies of NCH chunks each, NCH =
//  ceil((COORD_WIDTH + 2) / 17), at least 2. An Euler request adds 3 CORDIC
//  runs and 23 multiplies. One request is in work at a time; the next is
//  taken while a finished response waits. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module point_transform_euler_rotator #(
   parameter int COORD_WIDTH     = 32,
   parameter int ANGLE_WIDTH     = 16,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_cmd,
   input  logic signed [COORD_WIDTH-1:0] req_val_a,
   input  logic signed [COORD_WIDTH-1:0] req_val_b,
   input  logic signed [COORD_WIDTH-1:0] req_val_c,
   input  logic [ANGLE_WIDTH-1:0]        req_angle_a,
   input  logic [ANGLE_WIDTH-1:0]        req_angle_b,
   input  logic [ANGLE_WIDTH-1:0]        req_angle_g,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z
);
   import pter_pkg::*;

   localparam int NIT = (TRIG_ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH : TRIG_ITERATIONS;
   localparam int VW  = (COORD_WIDTH + 2 > MUL_B_WIDTH) ? COORD_WIDTH + 2 : MUL_B_WIDTH;
   localparam int RW  = VW + 4;
   localparam int SW  = RW + 2;
   localparam logic signed [SW-1:0] COORD_MAX =
      SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] COORD_MIN = ~COORD_MAX;

   state_type state_ff, state_in;
   logic [1:0]           trig_idx_ff, trig_idx_in;
   logic [UPC_WIDTH-1:0] upc_ff, upc_in;
   logic                 trig_start;
   logic                 mul_start;
   logic                 finish_go;

   cmd_type              cmd_ff;
   logic [ANGLE_WIDTH-1:0] ang_a_ff, ang_b_ff, ang_g_ff;
   logic signed [COORD_WIDTH-1:0] px_ff, py_ff, pz_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_valid_ff;

   logic signed [SW-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [SW-1:0] pvx_ff, pvy_ff, pvz_ff;
   logic signed [SW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [SW-1:0] sa_ff, ca_ff, sb_ff, cb_ff, sg_ff, cg_ff;
   logic signed [SW-1:0] sacb_ff, cacb_ff;
   logic signed [SW-1:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [SW-1:0] r20_ff, r21_ff;

   uop_type              uop;
   logic [ANGLE_WIDTH-1:0] trig_angle;
   logic                 trig_done;
   logic signed [TRIG_WIDTH-1:0] trig_sin, trig_cos;
   logic                 mul_done;
   logic signed [RW-1:0] mul_p;
   logic signed [SW-1:0] src_a_val, src_b_val, dst_old, dst_new, prod_ext;
   logic signed [SW-1:0] px_ext, py_ext, pz_ext;
   logic signed [SW-1:0] va_ext, vb_ext, vc_ext;
   logic signed [SW-1:0] sum_x, sum_y, sum_z;
   logic signed [COORD_WIDTH-1:0] sat_x, sat_y, sat_z;

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX;
      end else if (v < COORD_MIN) begin
         r = COORD_MIN;
      end else begin
         r = v;
      end
      return r[COORD_WIDTH-1:0];
   endfunction

   // Operand fetch for the shared multiplier.
   function automatic logic signed [SW-1:0] pick(
      input sel_type sel,
      input logic signed [SW-1:0] vpx, input logic signed [SW-1:0] vpy,
      input logic signed [SW-1:0] vpz);
      logic signed [SW-1:0] r;
      case (sel)
         SEL_PX:   r = vpx;
         SEL_PY:   r = vpy;
         SEL_PZ:   r = vpz;
         SEL_DX:   r = dx_ff;
         SEL_DY:   r = dy_ff;
         SEL_DZ:   r = dz_ff;
         SEL_SA:   r = sa_ff;
         SEL_CA:   r = ca_ff;
         SEL_SB:   r = sb_ff;
         SEL_CB:   r = cb_ff;
         SEL_SG:   r = sg_ff;
         SEL_CG:   r = cg_ff;
         SEL_SACB: r = sacb_ff;
         SEL_CACB: r = cacb_ff;
         SEL_R00:  r = r00_ff;
         SEL_R01:  r = r01_ff;
         SEL_R02:  r = r02_ff;
         SEL_R10:  r = r10_ff;
         SEL_R11:  r = r11_ff;
         SEL_R12:  r = r12_ff;
         SEL_R20:  r = r20_ff;
         SEL_R21:  r = r21_ff;
         SEL_NX:   r = nx_ff;
         SEL_NY:   r = ny_ff;
         SEL_NZ:   r = nz_ff;
         default:  r = '0;
      endcase
      return r;
   endfunction

   // Datapath selection and final saturation.
   always_comb begin
      uop       = uop_rom(upc_ff);
      px_ext    = SW'(px_ff);
      py_ext    = SW'(py_ff);
      pz_ext    = SW'(pz_ff);
      va_ext    = SW'(req_val_a);
      vb_ext    = SW'(req_val_b);
      vc_ext    = SW'(req_val_c);
      src_a_val = pick(uop.src_a, px_ext, py_ext, pz_ext);
      src_b_val = pick(uop.src_b, px_ext, py_ext, pz_ext);
      dst_old   = pick(uop.dst, px_ext, py_ext, pz_ext);
      prod_ext  = SW'(mul_p);
      case (uop.mop)
         MOP_SET: dst_new = prod_ext;
         MOP_ADD: dst_new = dst_old + prod_ext;
         MOP_SUB: dst_new = dst_old - prod_ext;
         MOP_NEG: dst_new = -prod_ext;
         default: dst_new = prod_ext;
      endcase
      case (trig_idx_ff)
         2'd1:    trig_angle = ang_b_ff;
         2'd2:    trig_angle = ang_g_ff;
         default: trig_angle = ang_a_ff;
      endcase
      sum_x = nx_ff + pvx_ff;
      sum_y = ny_ff + pvy_ff;
      sum_z = nz_ff + pvz_ff;
      sat_x = sat_coord(sum_x);
      sat_y = sat_coord(sum_y);
      sat_z = sat_coord(sum_z);
   end

   // Sequencer: next state and control strobes.
   always_comb begin
      state_in    = state_ff;
      trig_idx_in = trig_idx_ff;
      upc_in      = upc_ff;
      req_ready   = 1'b0;
      trig_start  = 1'b0;
      mul_start   = 1'b0;
      finish_go   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               trig_idx_in = 2'd0;
               case (cmd_type'(req_cmd))
                  CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z, CMD_EULER: state_in = ST_TRIG;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_TRIG: begin
            trig_start = 1'b1;
            state_in   = ST_TRIG_WAIT;
         end
         ST_TRIG_WAIT: begin
            if (trig_done) begin
               if (cmd_ff == CMD_EULER && trig_idx_ff != 2'd2) begin
                  trig_idx_in = trig_idx_ff + 2'd1;
                  state_in    = ST_TRIG;
               end else begin
                  state_in = ST_MUL;
                  case (cmd_ff)
                     CMD_ROT_X: upc_in = UPC_ROT_X;
                     CMD_ROT_Y: upc_in = UPC_ROT_Y;
                     CMD_ROT_Z: upc_in = UPC_ROT_Z;
                     default:   upc_in = UPC_EULER;
                  endcase
               end
            end
         end
         ST_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               if (uop.last) begin
                  state_in = ST_FINISH;
               end else begin
                  upc_in   = upc_ff + UPC_WIDTH'(1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish_go = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         trig_idx_ff  <= 2'd0;
         upc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         px_ff        <= '0;
         py_ff        <= '0;
         pz_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         trig_idx_ff <= trig_idx_in;
         upc_ff      <= upc_in;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // The saturated sum does not move while the request is finishing.
         if (state_ff == ST_FINISH) begin
            px_ff <= sat_x;
            py_ff <= sat_y;
            pz_ff <= sat_z;
         end
      end
   end

   // Request capture, working registers and response registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= cmd_type'(req_cmd);
         ang_a_ff <= req_angle_a;
         ang_b_ff <= req_angle_b;
         ang_g_ff <= req_angle_g;
         dx_ff    <= px_ext - va_ext;
         dy_ff    <= py_ext - vb_ext;
         dz_ff    <= pz_ext - vc_ext;
         case (cmd_type'(req_cmd))
            CMD_LOAD: begin
               nx_ff  <= va_ext;
               ny_ff  <= vb_ext;
               nz_ff  <= vc_ext;
               pvx_ff <= '0;
               pvy_ff <= '0;
               pvz_ff <= '0;
            end
            CMD_TRANSLATE: begin
               nx_ff  <= px_ext - va_ext;
               ny_ff  <= py_ext - vb_ext;
               nz_ff  <= pz_ext - vc_ext;
               pvx_ff <= '0;
               pvy_ff <= '0;
               pvz_ff <= '0;
            end
            CMD_EULER: begin
               nx_ff  <= px_ext;
               ny_ff  <= py_ext;
               nz_ff  <= pz_ext;
               pvx_ff <= va_ext;
               pvy_ff <= vb_ext;
               pvz_ff <= vc_ext;
            end
            default: begin
               nx_ff  <= px_ext;
               ny_ff  <= py_ext;
               nz_ff  <= pz_ext;
               pvx_ff <= '0;
               pvy_ff <= '0;
               pvz_ff <= '0;
            end
         endcase
      end
      if (state_ff == ST_TRIG_WAIT && trig_done) begin
         case (trig_idx_ff)
            2'd1: begin
               sb_ff <= SW'(trig_sin);
               cb_ff <= SW'(trig_cos);
            end
            2'd2: begin
               sg_ff <= SW'(trig_sin);
               cg_ff <= SW'(trig_cos);
            end
            default: begin
               sa_ff <= SW'(trig_sin);
               ca_ff <= SW'(trig_cos);
            end
         endcase
      end
      if (state_ff == ST_MUL_WAIT && mul_done) begin
         case (uop.dst)
            SEL_SACB: sacb_ff <= dst_new;
            SEL_CACB: cacb_ff <= dst_new;
            SEL_R00:  r00_ff  <= dst_new;
            SEL_R01:  r01_ff  <= dst_new;
            SEL_R02:  r02_ff  <= dst_new;
            SEL_R10:  r10_ff  <= dst_new;
            SEL_R11:  r11_ff  <= dst_new;
            SEL_R12:  r12_ff  <= dst_new;
            SEL_R20:  r20_ff  <= dst_new;
            SEL_R21:  r21_ff  <= dst_new;
            SEL_NX:   nx_ff   <= dst_new;
            SEL_NY:   ny_ff   <= dst_new;
            SEL_NZ:   nz_ff   <= dst_new;
            default: begin
            end
         endcase
      end
      if (finish_go) begin
         rsp_x_ff <= sat_x;
         rsp_y_ff <= sat_y;
         rsp_z_ff <= sat_z;
      end
   end

   pter_cordic #(
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .ITERATIONS  (NIT)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (trig_angle),
      .done    (trig_done),
      .sin_out (trig_sin),
      .cos_out (trig_cos)
   );

   pter_mul #(
      .A_WIDTH   (VW),
      .RES_WIDTH (RW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (src_a_val[VW-1:0]),
      .op_b    (src_b_val[MUL_B_WIDTH-1:0]),
      .done    (mul_done),
      .product (mul_p)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_z = rsp_z_ff;

endmodule

`default_nettype wire

@@ sv/pter_chk.sv @@
// ----------------------------------------------------------------------------
// pter_chk: port-level checks of the point transform rotator
// Watches the request and response handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pter_chk #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_out_x,
   input logic [COORD_WIDTH-1:0] rsp_out_y,
   input logic [COORD_WIDTH-1:0] rsp_out_z
);

   // Out of reset the block is idle with no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // A taken request keeps the block busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while still busy");

   // A response only appears after the block has been working.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_x)
                                     && $stable(rsp_out_y) && $stable(rsp_out_z)))
      else $error("stalled response changed");

endmodule

bind point_transform_euler_rotator pter_chk #(
   .COORD_WIDTH (COORD_WIDTH)
) u_pter_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_out_x (rsp_out_x),
   .rsp_out_y (rsp_out_y),
   .rsp_out_z (rsp_out_z)
);

`default_nettype wire

@@ dv/tb_point_transform_euler_rotator.sv @@
// ----------------------------------------------------------------------------
// tb_point_transform_euler_rotator: self-checking bench of the point rotator
// Drives load, translate, single-axis and Euler requests through the request
// channel, predicts every updated point with an independent fixed-point model
// and compares each response field by field, under varying back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_transform_euler_rotator;
   import pter_pkg::*;

   localparam int CW = 32;
   localparam int AW = 16;
   localparam int ITERS = 16;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } point_type;

   // Scoreboard: holds the tracked point and the queue of expected points.
   class point_scoreboard;
      longint px, py, pz;
      point_type pending[$];
      int errors;

      function new();
         px = 0; py = 0; pz = 0; errors = 0;
      endfunction

      // Prints one mismatch line and counts it.
      task report_mismatch(string what);
         errors++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      static function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      static function longint clamp(longint v);
         longint hi, lo;
         hi = (longint'(1) <<< (CW - 1)) - 1;
         lo = -hi - 1;
         return (v > hi) ? hi : ((v < lo) ? lo : v);
      endfunction

      // Q30 product rounded half up, computed exactly in 128 bits.
      static function longint qmul(longint a, longint b);
         logic signed [127:0] p;
         p = 128'(signed'(a)) * 128'(signed'(b)) + (128'sd1 <<< 29);
         return longint'(p >>> 30);
      endfunction

      static function longint arctan(int i);
         case (i)
            0: return 64'h20000000;  1: return 64'h12E4051E;
            2: return 64'h09FB385B;  3: return 64'h051111D4;
            4: return 64'h028B0D43;  5: return 64'h0145D7E1;
            6: return 64'h00A2F61E;  7: return 64'h00517C55;
            8: return 64'h0028BE53;  9: return 64'h00145F2F;
            10: return 64'h000A2F98; 11: return 64'h000517CC;
            12: return 64'h00028BE6; 13: return 64'h000145F3;
            14: return 64'h0000A2FA; 15: return 64'h0000517D;
            16: return 64'h000028BE; 17: return 64'h0000145F;
            18: return 64'h00000A30; 19: return 64'h00000518;
            20: return 64'h0000028C; 21: return 64'h00000146;
            22: return 64'h000000A3; default: return 64'h00000051;
         endcase
      endfunction

      // CORDIC sine and cosine of a binary angle, Q2.30.
      static function void trig(logic [AW-1:0] ang, output longint s, output longint c);
         logic [31:0] ph;
         bit flip;
         longint x, y, z, dx, dy;
         ph = {ang, {(32 - AW){1'b0}}};
         flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
         if (flip) ph = ph + 32'h80000000;
         x = 64'h26DD3B6A;
         y = 0;
         z = longint'(signed'(ph));
         for (int i = 0; i < ITERS && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= arctan(i);
            end else begin
               x += dx; y -= dy; z += arctan(i);
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         s = y;
         c = x;
      endfunction

      // Notes an accepted request and queues the point it produces.
      function void note_request(cmd_type cmd, longint va, longint vb, longint vc,
                                 logic [AW-1:0] aa, logic [AW-1:0] ab, logic [AW-1:0] ag);
         longint x, y, z, s, c, sa, ca, sb, cb, sg, cg, sacb, cacb, dx, dy, dz;
         longint r00, r01, r02, r10, r11, r12, r20, r21;
         point_type p;
         x = px; y = py; z = pz;
         case (cmd)
            CMD_LOAD: begin
               x = va; y = vb; z = vc;
            end
            CMD_TRANSLATE: begin
               x = clamp(px - va); y = clamp(py - vb); z = clamp(pz - vc);
            end
            CMD_ROT_X: begin
               trig(aa, s, c);
               y = clamp(qmul(py, c) - qmul(pz, s));
               z = clamp(qmul(py, s) + qmul(pz, c));
            end
            CMD_ROT_Y: begin
               trig(aa, s, c);
               x = clamp(qmul(px, c) + qmul(pz, s));
               z = clamp(qmul(pz, c) - qmul(px, s));
            end
            CMD_ROT_Z: begin
               trig(aa, s, c);
               x = clamp(qmul(px, c) + qmul(py, s));
               y = clamp(-qmul(px, s) + qmul(py, c));
            end
            CMD_EULER: begin
               dx = px - va; dy = py - vb; dz = pz - vc;
               trig(aa, sa, ca);
               trig(ab, sb, cb);
               trig(ag, sg, cg);
               sacb = qmul(sa, cb);
               cacb = qmul(ca, cb);
               r00 = qmul(ca, cg) - qmul(sacb, sg);
               r01 = qmul(sa, cg) + qmul(cacb, sg);
               r02 = qmul(sb, sg);
               r10 = -qmul(ca, sg) - qmul(sacb, cg);
               r11 = -qmul(sa, sg) + qmul(cacb, cg);
               r12 = qmul(sb, cg);
               r20 = qmul(sa, sb);
               r21 = -qmul(ca, sb);
               x = clamp(qmul(dx, r00) + qmul(dy, r01) + qmul(dz, r02) + va);
               y = clamp(qmul(dx, r10) + qmul(dy, r11) + qmul(dz, r12) + vb);
               z = clamp(qmul(dx, r20) + qmul(dy, r21) + qmul(dz, cb) + vc);
            end
            default: ;
         endcase
         px = x; py = y; pz = z;
         p.x = x[CW-1:0]; p.y = y[CW-1:0]; p.z = z[CW-1:0];
         pending.push_back(p);
      endfunction

      // Compares one response with the oldest expected point.
      task check_response(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                          logic signed [CW-1:0] z);
         point_type e;
         if (pending.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) report_mismatch($sformatf("out_x %h, predicted %h", x, e.x));
         if (y !== e.y) report_mismatch($sformatf("out_y %h, predicted %h", y, e.y));
         if (z !== e.z) report_mismatch($sformatf("out_z %h, predicted %h", z, e.z));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_cmd = '0;
   logic signed [CW-1:0] req_val_a = '0, req_val_b = '0, req_val_c = '0;
   logic [AW-1:0] req_angle_a = '0, req_angle_b = '0, req_angle_g = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;

   point_scoreboard board = new();
   int send_idle_pct = 15;
   int recv_idle_pct = 60;

   point_transform_euler_rotator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_val_a(req_val_a), .req_val_b(req_val_b), .req_val_c(req_val_c),
      .req_angle_a(req_angle_a), .req_angle_b(req_angle_b), .req_angle_g(req_angle_g),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: random back-pressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Responses are checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_out_x, rsp_out_y, rsp_out_z);
   end

   // Sends one request and waits until it is accepted; starts and ends at a
   // falling edge, leaving valid high for a following request.
   task automatic send_request(logic [2:0] cmd, logic [CW-1:0] va, logic [CW-1:0] vb,
                               logic [CW-1:0] vc, logic [AW-1:0] aa, logic [AW-1:0] ab,
                               logic [AW-1:0] ag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_val_a <= va; req_val_b <= vb; req_val_c <= vc;
      req_angle_a <= aa; req_angle_b <= ab; req_angle_g <= ag;
      do @(posedge clock); while (!req_ready);
      board.note_request(cmd_type'(cmd), longint'(signed'(va)), longint'(signed'(vb)),
                         longint'(signed'(vc)), aa, ab, ag);
      @(negedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h7FFFFFFF - $urandom_range(3);
         2: return 32'h80000000 + $urandom_range(3);
         default: return $urandom_range(32'h01000000) - 32'h00800000;
      endcase
   endfunction

   function automatic logic [AW-1:0] rand_angle();
      if ($urandom_range(3) == 0)
         return AW'(32'h4000 * $urandom_range(3) + $urandom_range(2) - 1);
      return AW'($urandom);
   endfunction

   initial begin
      logic [2:0] cmd;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: extremes, each command, quadrant edges, undefined codes.
      send_request(CMD_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, '0, '0, '0);
      send_request(CMD_ROT_X, '0, '0, '0, 16'h0000, '0, '0);
      send_request(CMD_ROT_Y, '0, '0, '0, 16'h4000, '0, '0);
      send_request(CMD_ROT_Z, '0, '0, '0, 16'h8000, '0, '0);
      send_request(CMD_ROT_X, '0, '0, '0, 16'hC000, '0, '0);
      send_request(CMD_ROT_Z, '0, '0, '0, 16'hFFFF, '0, '0);
      send_request(CMD_TRANSLATE, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, '0, '0, '0);
      send_request(CMD_TRANSLATE, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, '0, '0, '0);
      send_request(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(3'd7, '0, '0, '0, '0, '0, '0);
      send_request(CMD_LOAD, 32'h00030000, 32'hFFFE0000, 32'h00050000, '0, '0, '0);
      send_request(CMD_EULER, 32'h00010000, '0, 32'hFFFF0000, 16'h2000, 16'h7FFF, 16'hE000);
      send_request(CMD_EULER, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                   16'hFFFF, 16'h8000, 16'h0001);
      send_request(CMD_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0, '0);
      send_request(CMD_ROT_Y, '0, '0, '0, 16'h2000, '0, '0);
      send_request(CMD_EULER, 32'h80000000, 32'h80000000, 32'h80000000,
                   16'h6000, 16'hA000, 16'h3FFF);

      // Random part in three idling phases.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : ((phase == 1) ? 60 : 0);
         recv_idle_pct = (phase == 0) ? 60 : ((phase == 1) ? 15 : 0);
         for (int n = 0; n < 135; n++) begin
            case ($urandom_range(19))
               0, 1, 2: cmd = CMD_LOAD;
               3, 4: cmd = CMD_TRANSLATE;
               5, 6, 7: cmd = CMD_ROT_X;
               8, 9, 10: cmd = CMD_ROT_Y;
               11, 12, 13: cmd = CMD_ROT_Z;
               18: cmd = 3'(32'd6 + $urandom_range(1));
               default: cmd = CMD_EULER;
            endcase
            send_request(cmd, rand_coord(), rand_coord(), rand_coord(),
                         rand_angle(), rand_angle(), rand_angle());
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the longest request time to pass.
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
